@@ sv/tlpt_pkg.sv @@
// Package: shared types, constants and codes for the two-level page table walker.
`timescale 1ns / 1ps

package tlpt_pkg;

    localparam int L1_ENTRIES      = 4096;
    localparam int L2_ENTRIES      = 256;
    localparam int POOL_TABLES_DEF = 64;

    localparam int ADDR_W      = 32;
    localparam int PAGE_ATTR_W = 12;
    localparam int SECT_ATTR_W = 20;
    localparam int CFG_IDX_W   = 1;
    localparam int L1_IDX_W    = $clog2(L1_ENTRIES);
    localparam int L2_IDX_W    = $clog2(L2_ENTRIES);
    localparam int TABLE_SHIFT = L2_IDX_W + 2;
    localparam int PAGE_SHIFT  = 12;
    localparam int SECT_SHIFT  = ADDR_W - L1_IDX_W;

    typedef enum logic [1:0] {
        CMD_MAP       = 2'd0,
        CMD_TRANSLATE = 2'd1,
        CMD_SECTION   = 2'd2,
        CMD_CLEAR     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_TABLE = 2'd1,
        STAT_POOL_FULL = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BASE     = 1'b0,
        CFG_SECTION_ATTRS = 1'b1
    } cfg_idx_t;

    localparam logic [1:0] DESC_FAULT   = 2'd0;
    localparam logic [1:0] DESC_COARSE  = 2'd1;
    localparam logic [1:0] DESC_SECTION = 2'd2;
    localparam logic [1:0] DESC_SMALL   = 2'd2;

    typedef struct packed {
        logic [1:0]             cmd;
        logic [ADDR_W-1:0]      virt_addr;
        logic [ADDR_W-1:0]      phys_addr;
        logic [PAGE_ATTR_W-1:0] page_attrs;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              found;
        logic [ADDR_W-1:0] translated_addr;
    } out_item_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECIDE,
        S_L2_CLEAR,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic init_step;
        logic accept;
        logic decide;
        logic clr_step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic init_last;
        logic clr_last;
        logic need_clear;
        logic out_free;
    } dp_stat_t;

endpackage

@@ sv/tlpt_ctrl.sv @@
// Controller: sequences L1 clearing, lookup, table clearing and completion.
`timescale 1ns / 1ps

module tlpt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tlpt_pkg::dp_stat_t  stat,
    output tlpt_pkg::ctrl_cmd_t ctrl
);
    import tlpt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_INIT: begin
                if (stat.init_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) state_next = S_DECIDE;
            end
            S_DECIDE: begin
                state_next = stat.need_clear ? S_L2_CLEAR : S_FINISH;
            end
            S_L2_CLEAR: begin
                if (stat.clr_last) state_next = S_FINISH;
            end
            S_FINISH: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            default: state_next = S_INIT;
        endcase
    end

    always_comb begin
        ctrl    = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_INIT: begin
                ctrl.init_step = 1'b1;
            end
            S_IDLE: begin
                s_ready     = 1'b1;
                ctrl.accept = s_valid;
            end
            S_DECIDE: begin
                ctrl.decide = 1'b1;
            end
            S_L2_CLEAR: begin
                ctrl.clr_step = 1'b1;
            end
            S_FINISH: begin
                ctrl.finish = stat.out_free;
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

endmodule

@@ sv/tlpt_datapath.sv @@
// Datapath: config registers, L1 table and L2 pool memories, decode and result register.
`timescale 1ns / 1ps

module tlpt_datapath #(
    parameter int POOL_TABLES = tlpt_pkg::POOL_TABLES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tlpt_pkg::in_item_t                   s_data,
    input  logic                                 cfg_valid,
    input  logic [tlpt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tlpt_pkg::ADDR_W-1:0]          cfg_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output tlpt_pkg::out_item_t                  m_data,
    input  tlpt_pkg::ctrl_cmd_t                  ctrl,
    output tlpt_pkg::dp_stat_t                   stat
);
    import tlpt_pkg::*;

    localparam int TAB_W    = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
    localparam int CNT_W    = $clog2(POOL_TABLES + 1);
    localparam int L2_DEPTH = POOL_TABLES * L2_ENTRIES;
    localparam int L2_AW    = TAB_W + L2_IDX_W;
    localparam int NUM_W    = ADDR_W - TABLE_SHIFT;

    logic [ADDR_W-1:0]      l1_mem [0:L1_ENTRIES-1];
    logic [ADDR_W-1:0]      l2_mem [0:L2_DEPTH-1];

    logic [ADDR_W-1:0]      pool_base_reg;
    logic [SECT_ATTR_W-1:0] section_attrs_reg;
    logic [CNT_W-1:0]       pool_used_reg;
    logic [L1_IDX_W-1:0]    init_cnt_reg;
    logic [L2_IDX_W-1:0]    clr_cnt_reg;
    in_item_t               item_reg;
    logic [ADDR_W-1:0]      l1_rdata_reg;
    logic [ADDR_W-1:0]      l2_rdata_reg;
    logic [TAB_W-1:0]       tab_reg;
    logic                   alloc_reg;
    logic                   hit_reg;
    logic [1:0]             status_reg;
    logic                   m_valid_reg;
    out_item_t              m_data_reg;

    logic [1:0]             ftype;
    logic [ADDR_W-1:0]      base_aligned;
    logic [ADDR_W-1:0]      offset;
    logic [NUM_W-1:0]       tab_num;
    logic                   table_ok;
    logic                   pool_full;
    logic                   is_map;
    logic                   alloc;
    logic [1:0]             map_status;
    logic [TAB_W-1:0]       tab_sel;
    logic [L1_IDX_W-1:0]    l1i;
    logic [L2_IDX_W-1:0]    l2i;
    logic [ADDR_W-1:0]      pool_addr;
    logic [ADDR_W-1:0]      page_desc;
    logic [ADDR_W-1:0]      sect_desc;

    logic                   l1_we;
    logic [L1_IDX_W-1:0]    l1_waddr;
    logic [ADDR_W-1:0]      l1_wdata;
    logic                   l2_we;
    logic [L2_AW-1:0]       l2_waddr;
    logic [ADDR_W-1:0]      l2_wdata;
    out_item_t              result;

    assign l1i          = item_reg.virt_addr[ADDR_W-1 -: L1_IDX_W];
    assign l2i          = item_reg.virt_addr[PAGE_SHIFT +: L2_IDX_W];
    assign ftype        = l1_rdata_reg[1:0];
    assign base_aligned = {pool_base_reg[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    assign offset       = {l1_rdata_reg[ADDR_W-1:TABLE_SHIFT], {TABLE_SHIFT{1'b0}}}
                          - base_aligned;
    assign tab_num      = offset[ADDR_W-1:TABLE_SHIFT];
    assign table_ok     = (ftype == DESC_COARSE) && (tab_num < NUM_W'(pool_used_reg));
    assign pool_full    = (pool_used_reg == CNT_W'(POOL_TABLES));
    assign is_map       = (item_reg.cmd == CMD_MAP);
    assign alloc        = is_map && (ftype == DESC_FAULT) && !pool_full;
    assign tab_sel      = alloc ? pool_used_reg[TAB_W-1:0] : tab_num[TAB_W-1:0];

    always_comb begin
        if (ftype == DESC_FAULT) begin
            map_status = pool_full ? STAT_POOL_FULL : STAT_OK;
        end else begin
            map_status = table_ok ? STAT_OK : STAT_NOT_TABLE;
        end
    end

    assign pool_addr = base_aligned + (ADDR_W'(tab_reg) << TABLE_SHIFT);
    assign page_desc = {item_reg.phys_addr[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}}
                       | {{(ADDR_W-PAGE_ATTR_W){1'b0}}, item_reg.page_attrs}
                       | {{(ADDR_W-2){1'b0}}, DESC_SMALL};
    assign sect_desc = {item_reg.phys_addr[ADDR_W-1:SECT_SHIFT], {SECT_SHIFT{1'b0}}}
                       | {{(ADDR_W-SECT_ATTR_W){1'b0}}, section_attrs_reg}
                       | {{(ADDR_W-2){1'b0}}, DESC_SECTION};

    // L1 write port
    always_comb begin
        l1_we    = 1'b0;
        l1_waddr = l1i;
        l1_wdata = '0;
        if (ctrl.init_step) begin
            l1_we    = 1'b1;
            l1_waddr = init_cnt_reg;
        end else if (ctrl.finish) begin
            case (item_reg.cmd)
                CMD_MAP: begin
                    l1_we    = alloc_reg;
                    l1_wdata = pool_addr | {{(ADDR_W-2){1'b0}}, DESC_COARSE};
                end
                CMD_SECTION: begin
                    l1_we    = 1'b1;
                    l1_wdata = sect_desc;
                end
                CMD_CLEAR: begin
                    l1_we = 1'b1;
                end
                default: begin
                    l1_we = 1'b0;
                end
            endcase
        end
    end

    // L2 write port
    always_comb begin
        l2_we    = 1'b0;
        l2_waddr = {tab_reg, l2i};
        l2_wdata = page_desc;
        if (ctrl.clr_step) begin
            l2_we    = 1'b1;
            l2_waddr = {tab_reg, clr_cnt_reg};
            l2_wdata = '0;
        end else if (ctrl.finish && is_map && (status_reg == STAT_OK)) begin
            l2_we = 1'b1;
        end
    end

    always_comb begin
        result        = '0;
        result.status = status_reg;
        if (item_reg.cmd == CMD_TRANSLATE) begin
            if (hit_reg) begin
                if (l2_rdata_reg[1:0] == DESC_SMALL) begin
                    result.found           = 1'b1;
                    result.translated_addr = {l2_rdata_reg[ADDR_W-1:PAGE_SHIFT],
                                              item_reg.virt_addr[PAGE_SHIFT-1:0]};
                end
            end else if (ftype == DESC_SECTION) begin
                result.found           = 1'b1;
                result.translated_addr = {l1_rdata_reg[ADDR_W-1:SECT_SHIFT],
                                          item_reg.virt_addr[SECT_SHIFT-1:0]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (l1_we) l1_mem[l1_waddr] <= l1_wdata;
        if (ctrl.accept) l1_rdata_reg <= l1_mem[s_data.virt_addr[ADDR_W-1 -: L1_IDX_W]];
    end

    always_ff @(posedge aclk) begin
        if (l2_we) l2_mem[l2_waddr] <= l2_wdata;
        if (ctrl.decide) l2_rdata_reg <= l2_mem[{tab_sel, l2i}];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.accept) item_reg <= s_data;
        if (ctrl.decide) begin
            tab_reg    <= tab_sel;
            alloc_reg  <= alloc;
            hit_reg    <= table_ok;
            status_reg <= is_map ? map_status : STAT_OK;
        end
        if (ctrl.finish) m_data_reg <= result;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg     <= '0;
            section_attrs_reg <= '0;
            pool_used_reg     <= '0;
            init_cnt_reg      <= '0;
            clr_cnt_reg       <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_POOL_BASE:     pool_base_reg     <= cfg_data;
                    CFG_SECTION_ATTRS: section_attrs_reg <= cfg_data[SECT_ATTR_W-1:0];
                    default: begin
                        pool_base_reg <= pool_base_reg;
                    end
                endcase
            end
            if (ctrl.init_step) init_cnt_reg <= init_cnt_reg + 1'b1;
            if (ctrl.decide) begin
                clr_cnt_reg <= '0;
            end else if (ctrl.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (ctrl.finish && alloc_reg && is_map) pool_used_reg <= pool_used_reg + 1'b1;
            if (ctrl.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.init_last  = (init_cnt_reg == L1_IDX_W'(L1_ENTRIES - 1));
    assign stat.clr_last   = (clr_cnt_reg == L2_IDX_W'(L2_ENTRIES - 1));
    assign stat.need_clear = alloc;
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ sv/two_level_page_table_map_walk_core.sv @@
// Top level: two-level short-descriptor page table with map, translate, section and clear.
`timescale 1ns / 1ps

// After reset the block clears its 4096-entry first-level table, one entry per cycle,
// and holds s_ready low while it does so; configuration writes are taken
// throughout. Each command transaction then passes through the accepting cycle, whose
// edge reads the first-level entry, a decode cycle that also reads the second-level
// entry, and a completion cycle that loads the output register; m_valid rises in the
// cycle after completion, when the next transaction can also be accepted.
// A map that allocates a new second-level table clears it through the single pool
// write port before completion. One command is in flight at a time; completion waits
// while the previous result has not been taken on the m_ side. Configuration is written
// through the cfg_ channel, index 0 for pool_base and 1 for section_attrs, and is always
// ready.

module two_level_page_table_map_walk_core #(
    parameter int POOL_TABLES = tlpt_pkg::POOL_TABLES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tlpt_pkg::in_item_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tlpt_pkg::out_item_t            m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tlpt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tlpt_pkg::ADDR_W-1:0]    cfg_data
);
    import tlpt_pkg::*;

    ctrl_cmd_t ctrl;
    dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    tlpt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    tlpt_datapath #(
        .POOL_TABLES (POOL_TABLES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .ctrl      (ctrl),
        .stat      (stat)
    );

endmodule
